>>> rtl/vdp_pkg.sv
// Shared constants, types and a saturation helper for the Van der Pol RK4 stepper.
package vdp_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 20;
	localparam int DT_BITS   = WORD_BITS - 1;
	localparam int CFG_BITS  = 3;
	localparam int PROD_BITS = 2 * WORD_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [WORD_BITS+1:0] sum_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t ONE_FX   = (FRAC_BITS >= WORD_BITS - 1) ? WORD_MAX
		: word_t'(64'sd1 << FRAC_BITS);

	typedef enum logic [CFG_BITS-1:0] {
		REG_MU  = 3'd0,
		REG_W0  = 3'd1,
		REG_DT  = 3'd2,
		REG_X0  = 3'd3,
		REG_V0  = 3'd4
	} cfg_reg_t;

	// Operation codes of the shared ALU.
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    half;   // product shift by FRAC_BITS+1
	} alu_ctl_t;

	// Clamp a sum carrying two guard bits.
	function automatic logic [WORD_BITS:0] clamp_sum(input sum_t s);
		logic [WORD_BITS:0] r;
		if (s > sum_t'(WORD_MAX))
			r = {1'b1, WORD_MAX};
		else if (s < sum_t'(WORD_MIN))
			r = {1'b1, WORD_MIN};
		else
			r = {1'b0, s[WORD_BITS-1:0]};
		return r;
	endfunction

endpackage

>>> rtl/vdp_alu.sv
// Shared arithmetic unit: registered multiply, then floor shift and saturate; add/sub.
module vdp_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vdp_pkg::alu_ctl_t ctl,
	input  vdp_pkg::word_t  a,
	input  vdp_pkg::word_t  b,
	output vdp_pkg::word_t  result,
	output logic            sat
);

	vdp_pkg::prod_t prod_s1;
	logic           half_s1;
	logic           mul_s1;
	vdp_pkg::word_t add_res;
	logic           add_sat;
	vdp_pkg::prod_t shifted;
	vdp_pkg::word_t mul_res;
	logic           mul_sat;
	logic [vdp_pkg::WORD_BITS:0] add_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1 <= 1'b0;
		end else begin
			mul_s1 <= start && (ctl.op == vdp_pkg::OP_MUL);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= vdp_pkg::prod_t'(a) * vdp_pkg::prod_t'(b);
		half_s1 <= ctl.half;
	end

	// Arithmetic shift floors; a 64-bit product of two words cannot overflow.
	always_comb begin
		shifted = half_s1 ? (prod_s1 >>> (vdp_pkg::FRAC_BITS + 1))
		                  : (prod_s1 >>> vdp_pkg::FRAC_BITS);
		mul_sat = 1'b0;
		mul_res = shifted[vdp_pkg::WORD_BITS-1:0];
		if (shifted > vdp_pkg::prod_t'(vdp_pkg::WORD_MAX)) begin
			mul_sat = 1'b1;
			mul_res = vdp_pkg::WORD_MAX;
		end else if (shifted < vdp_pkg::prod_t'(vdp_pkg::WORD_MIN)) begin
			mul_sat = 1'b1;
			mul_res = vdp_pkg::WORD_MIN;
		end
	end

	always_comb begin
		if (ctl.op == vdp_pkg::OP_SUB)
			add_c = vdp_pkg::clamp_sum(vdp_pkg::sum_t'(a) - vdp_pkg::sum_t'(b));
		else
			add_c = vdp_pkg::clamp_sum(vdp_pkg::sum_t'(a) + vdp_pkg::sum_t'(b));
		add_res = add_c[vdp_pkg::WORD_BITS-1:0];
		add_sat = add_c[vdp_pkg::WORD_BITS];
	end

	// Multiply results come from the product register in the cycle after start; add/sub are combinational.
	assign result = mul_s1 ? mul_res : add_res;
	assign sat    = mul_s1 ? mul_sat : add_sat;

endmodule

>>> rtl/van_der_pol_rk4_stepper_unit.sv
// Top level of the Van der Pol RK4 stepper: sequencer, state and stream ports.
// One item runs through a microcoded sequence on a single shared multiplier/adder:
// 25 multiplies, 34 adds/subtracts and two divides by six, then the output register
// is loaded. Four derivative evaluations are chained, and each step starts from the
// last state unless s_tuser asks for a restart from the configured initial state.
// The next item is accepted in the cycle after the output register is loaded, so a
// new item is not taken while one is in progress; a result waiting at the output
// holds back only the end of the next step.
// Divide by six is done as a multiply by a reciprocal with one correction.
module van_der_pol_rk4_stepper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // coupling_force
	input  logic        s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // new_position, new_velocity
	output logic        m_tuser,   // saturated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_OUT} state_t;

	// Register file slots used by the microcode.
	typedef enum logic [4:0] {
		R_X, R_V, R_MU, R_W2, R_F, R_DT, R_ONE, R_TX, R_TV, R_T0, R_T1,
		R_KV1, R_KV2, R_KV3, R_KV4, R_KX1, R_KX2, R_KX3, R_KX4, R_SX, R_SV,
		R_W0, R_PX, R_PV, R_ZERO
	} rsel_t;

	typedef struct packed {
		vdp_pkg::alu_op_t op;
		logic  half;
		rsel_t a;
		rsel_t b;
		rsel_t d;
	} uop_t;

	state_t         state_q;
	logic [5:0]     pc_q;
	logic           phase_q;
	logic           sat_q;
	vdp_pkg::word_t rf_q [25];
	vdp_pkg::word_t mu_q, w0_q, x0_q, v0_q;
	logic [vdp_pkg::DT_BITS-1:0] dt_q;
	uop_t           uop;
	vdp_pkg::alu_ctl_t ctl;
	vdp_pkg::word_t alu_res;
	logic           alu_sat;
	logic           alu_start;
	logic           step_done;
	logic [1:0]     div_q;
	logic signed [67:0] recip_q;
	vdp_pkg::word_t q_q;
	vdp_pkg::word_t out_x_q, out_v_q;
	logic           out_vld_q;
	logic           out_sat_q;
	logic           out_load;

	function automatic uop_t mk(vdp_pkg::alu_op_t o, logic h, rsel_t a, rsel_t b, rsel_t d);
		uop_t u;
		u.op = o; u.half = h; u.a = a; u.b = b; u.d = d;
		return u;
	endfunction

	function automatic uop_t ucode(input logic [5:0] pc);
		uop_t u;
		u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_ZERO, R_T0);
		case (pc)
			6'd0:  u = mk(vdp_pkg::OP_MUL, 1'b0, R_W0, R_W0, R_W2);
			6'd1:  u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_ZERO, R_T0);
			6'd2:  u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_ZERO, R_T0);
			6'd3:  u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_ZERO, R_T0);
			6'd4:  u = mk(vdp_pkg::OP_ADD, 1'b0, R_V, R_ZERO, R_KX1);
			// k1: accel(x, v)
			6'd5:  u = mk(vdp_pkg::OP_MUL, 1'b0, R_X, R_X, R_T0);
			6'd6:  u = mk(vdp_pkg::OP_SUB, 1'b0, R_ONE, R_T0, R_T0);
			6'd7:  u = mk(vdp_pkg::OP_MUL, 1'b0, R_MU, R_T0, R_T0);
			6'd8:  u = mk(vdp_pkg::OP_MUL, 1'b0, R_T0, R_V, R_T0);
			6'd9:  u = mk(vdp_pkg::OP_MUL, 1'b0, R_W2, R_X, R_T1);
			6'd10: u = mk(vdp_pkg::OP_SUB, 1'b0, R_T0, R_T1, R_T0);
			6'd11: u = mk(vdp_pkg::OP_ADD, 1'b0, R_T0, R_F, R_KV1);
			6'd12: u = mk(vdp_pkg::OP_MUL, 1'b1, R_DT, R_KX1, R_T0);
			6'd13: u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_T0, R_TX);
			6'd14: u = mk(vdp_pkg::OP_MUL, 1'b1, R_DT, R_KV1, R_T0);
			6'd15: u = mk(vdp_pkg::OP_ADD, 1'b0, R_V, R_T0, R_KX2);
			// k2
			6'd16: u = mk(vdp_pkg::OP_MUL, 1'b0, R_TX, R_TX, R_T0);
			6'd17: u = mk(vdp_pkg::OP_SUB, 1'b0, R_ONE, R_T0, R_T0);
			6'd18: u = mk(vdp_pkg::OP_MUL, 1'b0, R_MU, R_T0, R_T0);
			6'd19: u = mk(vdp_pkg::OP_MUL, 1'b0, R_T0, R_KX2, R_T0);
			6'd20: u = mk(vdp_pkg::OP_MUL, 1'b0, R_W2, R_TX, R_T1);
			6'd21: u = mk(vdp_pkg::OP_SUB, 1'b0, R_T0, R_T1, R_T0);
			6'd22: u = mk(vdp_pkg::OP_ADD, 1'b0, R_T0, R_F, R_KV2);
			6'd23: u = mk(vdp_pkg::OP_MUL, 1'b1, R_DT, R_KX2, R_T0);
			6'd24: u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_T0, R_TX);
			6'd25: u = mk(vdp_pkg::OP_MUL, 1'b1, R_DT, R_KV2, R_T0);
			6'd26: u = mk(vdp_pkg::OP_ADD, 1'b0, R_V, R_T0, R_KX3);
			// k3
			6'd27: u = mk(vdp_pkg::OP_MUL, 1'b0, R_TX, R_TX, R_T0);
			6'd28: u = mk(vdp_pkg::OP_SUB, 1'b0, R_ONE, R_T0, R_T0);
			6'd29: u = mk(vdp_pkg::OP_MUL, 1'b0, R_MU, R_T0, R_T0);
			6'd30: u = mk(vdp_pkg::OP_MUL, 1'b0, R_T0, R_KX3, R_T0);
			6'd31: u = mk(vdp_pkg::OP_MUL, 1'b0, R_W2, R_TX, R_T1);
			6'd32: u = mk(vdp_pkg::OP_SUB, 1'b0, R_T0, R_T1, R_T0);
			6'd33: u = mk(vdp_pkg::OP_ADD, 1'b0, R_T0, R_F, R_KV3);
			6'd34: u = mk(vdp_pkg::OP_MUL, 1'b0, R_DT, R_KX3, R_T0);
			6'd35: u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_T0, R_TX);
			6'd36: u = mk(vdp_pkg::OP_MUL, 1'b0, R_DT, R_KV3, R_T0);
			6'd37: u = mk(vdp_pkg::OP_ADD, 1'b0, R_V, R_T0, R_KX4);
			// k4
			6'd38: u = mk(vdp_pkg::OP_MUL, 1'b0, R_TX, R_TX, R_T0);
			6'd39: u = mk(vdp_pkg::OP_SUB, 1'b0, R_ONE, R_T0, R_T0);
			6'd40: u = mk(vdp_pkg::OP_MUL, 1'b0, R_MU, R_T0, R_T0);
			6'd41: u = mk(vdp_pkg::OP_MUL, 1'b0, R_T0, R_KX4, R_T0);
			6'd42: u = mk(vdp_pkg::OP_MUL, 1'b0, R_W2, R_TX, R_T1);
			6'd43: u = mk(vdp_pkg::OP_SUB, 1'b0, R_T0, R_T1, R_T0);
			6'd44: u = mk(vdp_pkg::OP_ADD, 1'b0, R_T0, R_F, R_KV4);
			// weighted sums
			6'd45: u = mk(vdp_pkg::OP_ADD, 1'b0, R_KX1, R_KX2, R_SX);
			6'd46: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SX, R_KX2, R_SX);
			6'd47: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SX, R_KX3, R_SX);
			6'd48: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SX, R_KX3, R_SX);
			6'd49: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SX, R_KX4, R_SX);
			6'd50: u = mk(vdp_pkg::OP_ADD, 1'b0, R_KV1, R_KV2, R_SV);
			6'd51: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SV, R_KV2, R_SV);
			6'd52: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SV, R_KV3, R_SV);
			6'd53: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SV, R_KV3, R_SV);
			6'd54: u = mk(vdp_pkg::OP_ADD, 1'b0, R_SV, R_KV4, R_SV);
			6'd55: u = mk(vdp_pkg::OP_MUL, 1'b0, R_DT, R_SX, R_PX);
			6'd56: u = mk(vdp_pkg::OP_MUL, 1'b0, R_DT, R_SV, R_PV);
			// 57: PX/6 via divider sequence, 58: x += q
			6'd58: u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_T0, R_X);
			// 60: v += q
			6'd60: u = mk(vdp_pkg::OP_ADD, 1'b0, R_V, R_T0, R_V);
			default: u = mk(vdp_pkg::OP_ADD, 1'b0, R_X, R_ZERO, R_T0);
		endcase
		return u;
	endfunction

	assign uop = ucode(pc_q);
	assign ctl = '{op: uop.op, half: uop.half};
	assign alu_start = (state_q == ST_RUN) && !phase_q;

	vdp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.ctl    (ctl),
		.a      (rf_q[uop.a]),
		.b      (rf_q[uop.b]),
		.result (alu_res),
		.sat    (alu_sat)
	);

	// Result is ready now for add/sub, next cycle for multiply.
	assign step_done = (uop.op != vdp_pkg::OP_MUL) || phase_q;

	// Output register takes the result when empty or when its transfer happens now.
	assign out_load = (state_q == ST_OUT) && (!out_vld_q || m_tready);

	// floor(a/6): q0 = (a * ceil(2^34/6)) >>> 34 is within one of the answer.
	localparam logic signed [35:0] RECIP6 = 36'sd2863311531;
	vdp_pkg::word_t div_src;
	logic signed [67:0] q_est;
	logic signed [35:0] rem_est;
	assign div_src = (pc_q == 6'd57) ? rf_q[R_PX] : rf_q[R_PV];
	assign q_est   = recip_q >>> 34;
	assign rem_est = 36'(div_src) - 36'(q_q) * 36'sd6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			phase_q <= 1'b0;
			sat_q   <= 1'b0;
			div_q   <= '0;
			recip_q <= '0;
			q_q     <= '0;
			mu_q    <= vdp_pkg::ONE_FX;
			w0_q    <= vdp_pkg::ONE_FX;
			dt_q    <= vdp_pkg::DT_BITS'(10486);
			x0_q    <= '0;
			v0_q    <= '0;
			rf_q    <= '{default: '0};
			out_vld_q <= 1'b0;
			out_sat_q <= 1'b0;
			out_x_q   <= '0;
			out_v_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					vdp_pkg::REG_MU: mu_q <= cfg_wdata;
					vdp_pkg::REG_W0: w0_q <= cfg_wdata;
					vdp_pkg::REG_DT: dt_q <= cfg_wdata[vdp_pkg::DT_BITS-1:0];
					vdp_pkg::REG_X0: x0_q <= cfg_wdata;
					vdp_pkg::REG_V0: v0_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_x_q   <= rf_q[R_X];
				out_v_q   <= rf_q[R_V];
				out_sat_q <= sat_q;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser) begin
							rf_q[R_X] <= x0_q;
							rf_q[R_V] <= v0_q;
						end
						rf_q[R_F]   <= s_tdata;
						rf_q[R_MU]  <= mu_q;
						rf_q[R_W0]  <= w0_q;
						rf_q[R_DT]  <= vdp_pkg::word_t'({1'b0, dt_q});
						rf_q[R_ONE] <= vdp_pkg::ONE_FX;
						sat_q   <= 1'b0;
						pc_q    <= '0;
						phase_q <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (pc_q == 6'd57 || pc_q == 6'd59) begin
						div_q   <= '0;
						state_q <= ST_DIV;
					end else if (!step_done) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						rf_q[uop.d] <= alu_res;
						sat_q <= sat_q | alu_sat;
						if (pc_q == 6'd60)
							state_q <= ST_OUT;
						pc_q <= pc_q + 6'd1;
					end
				end
				ST_DIV: begin
					div_q <= div_q + 2'd1;
					case (div_q)
						2'd0: recip_q <= 68'(div_src) * 68'(RECIP6);
						2'd1: q_q <= vdp_pkg::word_t'(q_est[31:0]);
						default: begin
							if (rem_est < 0)
								rf_q[R_T0] <= q_q - vdp_pkg::word_t'(1);
							else if (rem_est >= 36'sd6)
								rf_q[R_T0] <= q_q + vdp_pkg::word_t'(1);
							else
								rf_q[R_T0] <= q_q;
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_RUN;
						end
					endcase
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_v_q, out_x_q};
	assign m_tuser  = out_sat_q;

endmodule
